// ===== hdl/ndt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndt_pkg
// Shared types and constants for the layout transpose index unit.
// ----------------------------------------------------------------------------
package ndt_pkg;

   localparam int MAX_DIMS   = 6;
   localparam int INDEX_BITS = 32;
   localparam int EXT_BITS   = 16;
   localparam int DIM_BITS   = 3;
   localparam int ADDR_BITS  = 5;
   localparam int DATA_BITS  = 32;

   // register word indexes on the configuration port
   localparam logic [2:0] REG_DIRECTION = 3'd0;
   localparam logic [2:0] REG_DIM_COUNT = 3'd1;
   localparam logic [2:0] REG_EXTENT_0  = 3'd2;
   localparam logic [2:0] REG_EXTENT_1  = 3'd3;
   localparam logic [2:0] REG_EXTENT_2  = 3'd4;
   localparam logic [2:0] REG_EXTENT_3  = 3'd5;
   localparam logic [2:0] REG_EXTENT_4  = 3'd6;
   localparam logic [2:0] REG_EXTENT_5  = 3'd7;

   typedef logic [MAX_DIMS-1:0][EXT_BITS-1:0] ext_vec_type;

   // payload moving through the digit chain
   typedef struct packed {
      logic                  oor;
      logic [INDEX_BITS-1:0] idx;
      ext_vec_type           coord;
   } digit_type;

   // payload moving through the recombine chain
   typedef struct packed {
      logic                  oor;
      logic [INDEX_BITS-1:0] acc;
      ext_vec_type           coord;
   } horner_type;

endpackage

// ===== hdl/ndt_digit_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndt_digit_cell
// One index bit into the mixed-radix coordinate counter: double and add.
// ----------------------------------------------------------------------------
module ndt_digit_cell
   import ndt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        direction,
   input  ext_vec_type ext_eff,
   input  logic        valid_in,
   input  digit_type   data_in,
   output logic        valid_out,
   output digit_type   data_out
);

   logic      valid_ff;
   digit_type data_ff;
   digit_type data_in_c;

   always_comb begin
      logic              carry;
      logic [EXT_BITS:0] val;
      logic [DIM_BITS-1:0] k;
      data_in_c     = data_in;
      carry         = data_in.idx[INDEX_BITS-1];
      data_in_c.idx = {data_in.idx[INDEX_BITS-2:0], 1'b0};
      // walk from fastest digit to slowest of the destination layout
      for (int p = 0; p < MAX_DIMS; p++) begin
         k   = direction ? DIM_BITS'(p) : DIM_BITS'(MAX_DIMS - 1 - p);
         val = {data_in.coord[k], carry};
         if (val >= {1'b0, ext_eff[k]}) begin
            val   = val - {1'b0, ext_eff[k]};
            carry = 1'b1;
         end else begin
            carry = 1'b0;
         end
         data_in_c.coord[k] = val[EXT_BITS-1:0];
      end
      // overflow past the slowest digit: index reached the element count
      data_in_c.oor = data_in.oor | carry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in_c;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

// ===== hdl/ndt_horner_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndt_horner_cell
// One multiply-add step of the source index recombination.
// ----------------------------------------------------------------------------
module ndt_horner_cell
   import ndt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [EXT_BITS-1:0] ext_in,
   input  logic [EXT_BITS-1:0] digit_in,
   input  logic                valid_in,
   input  horner_type          data_in,
   output logic                valid_out,
   output horner_type          data_out
);

   logic                             valid_ff;
   horner_type                       data_ff;
   horner_type                       data_in_c;
   logic [INDEX_BITS+EXT_BITS-1:0]   prod;

   always_comb begin
      prod          = data_in.acc * ext_in;
      data_in_c     = data_in;
      data_in_c.acc = prod[INDEX_BITS-1:0]
                    + {{(INDEX_BITS-EXT_BITS){1'b0}}, digit_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in_c;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

// ===== hdl/nd_layout_transpose_index_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nd_layout_transpose_index_unit
// Row-major / column-major linear index converter for tensors of up to six
// dimensions.
//
//   channel   ports                                   handshake
//   request   start, busy, req_dest_index             start && !busy
//   result    rsp_valid, rsp_source_index,            one-cycle strobe
//             rsp_out_of_range
//   config    psel, penable, pwrite, paddr, pwdata,   APB, pready always high
//             prdata, pready
//
// One request per cycle, every cycle; busy is always low. 32 digit cells
// (one destination index bit each, MSB first) build the mixed-radix
// coordinates, 6 multiply-add cells recombine them with the source strides,
// and one output register drives the result ports. Reset is synchronous,
// sets the configuration to direction 0, one dimension and all extents of 1,
// and clears all valid bits. The receiver cannot stall, so nothing in the pipeline ever holds.
// ----------------------------------------------------------------------------
module nd_layout_transpose_index_unit
   import ndt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [INDEX_BITS-1:0] req_dest_index,
   // result channel
   output logic                  rsp_valid,
   output logic [INDEX_BITS-1:0] rsp_source_index,
   output logic                  rsp_out_of_range,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_BITS-1:0]  paddr,
   input  logic [DATA_BITS-1:0]  pwdata,
   output logic [DATA_BITS-1:0]  prdata,
   output logic                  pready
);

   // ---------------------------------------------------------------- config
   logic                direction_ff;
   logic [DIM_BITS-1:0] dim_count_ff;
   ext_vec_type         extent_ff;
   logic                cfg_write;
   logic [2:0]          reg_sel;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;
   assign reg_sel   = paddr[ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         dim_count_ff <= DIM_BITS'(1);
         for (int k = 0; k < MAX_DIMS; k++) begin
            extent_ff[k] <= EXT_BITS'(1);
         end
      end else if (cfg_write) begin
         case (reg_sel)
            REG_DIRECTION: direction_ff <= pwdata[0];
            REG_DIM_COUNT: dim_count_ff <= pwdata[DIM_BITS-1:0];
            REG_EXTENT_0:  extent_ff[0] <= pwdata[EXT_BITS-1:0];
            REG_EXTENT_1:  extent_ff[1] <= pwdata[EXT_BITS-1:0];
            REG_EXTENT_2:  extent_ff[2] <= pwdata[EXT_BITS-1:0];
            REG_EXTENT_3:  extent_ff[3] <= pwdata[EXT_BITS-1:0];
            REG_EXTENT_4:  extent_ff[4] <= pwdata[EXT_BITS-1:0];
            REG_EXTENT_5:  extent_ff[5] <= pwdata[EXT_BITS-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_DIRECTION: prdata = {{(DATA_BITS-1){1'b0}}, direction_ff};
         REG_DIM_COUNT: prdata = {{(DATA_BITS-DIM_BITS){1'b0}}, dim_count_ff};
         REG_EXTENT_0:  prdata = {{(DATA_BITS-EXT_BITS){1'b0}}, extent_ff[0]};
         REG_EXTENT_1:  prdata = {{(DATA_BITS-EXT_BITS){1'b0}}, extent_ff[1]};
         REG_EXTENT_2:  prdata = {{(DATA_BITS-EXT_BITS){1'b0}}, extent_ff[2]};
         REG_EXTENT_3:  prdata = {{(DATA_BITS-EXT_BITS){1'b0}}, extent_ff[3]};
         REG_EXTENT_4:  prdata = {{(DATA_BITS-EXT_BITS){1'b0}}, extent_ff[4]};
         REG_EXTENT_5:  prdata = {{(DATA_BITS-EXT_BITS){1'b0}}, extent_ff[5]};
         default:       prdata = '0;
      endcase
   end

   // Clamp the dimension count to 1..MAX_DIMS and force unused extents to 1,
   // which makes those digits transparent in both chains.
   logic [DIM_BITS-1:0] dims_used;
   ext_vec_type         ext_eff;
   logic                ext_zero;

   always_comb begin
      if (dim_count_ff == '0) begin
         dims_used = DIM_BITS'(1);
      end else if (dim_count_ff > DIM_BITS'(MAX_DIMS)) begin
         dims_used = DIM_BITS'(MAX_DIMS);
      end else begin
         dims_used = dim_count_ff;
      end
      for (int k = 0; k < MAX_DIMS; k++) begin
         ext_eff[k] = (DIM_BITS'(k) < dims_used) ? extent_ff[k] : EXT_BITS'(1);
      end
      // a used zero extent empties the tensor: flag every request up front
      ext_zero = 1'b0;
      for (int k = 0; k < MAX_DIMS; k++) begin
         if (ext_eff[k] == '0) begin
            ext_zero = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------- digit chain
   logic      d_valid [INDEX_BITS+1];
   digit_type d_data  [INDEX_BITS+1];

   assign busy              = 1'b0;
   assign d_valid[0]        = start;
   assign d_data[0].oor     = ext_zero;
   assign d_data[0].idx     = req_dest_index;
   assign d_data[0].coord   = '0;

   for (genvar i = 0; i < INDEX_BITS; i++) begin : g_digit
      ndt_digit_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .direction (direction_ff),
         .ext_eff   (ext_eff),
         .valid_in  (d_valid[i]),
         .data_in   (d_data[i]),
         .valid_out (d_valid[i+1]),
         .data_out  (d_data[i+1])
      );
   end

   // ------------------------------------------------------- recombine chain
   // Source Horner order: direction 0 runs dims last to first, direction 1
   // first to last.
   logic                h_valid [MAX_DIMS+1];
   horner_type          h_data  [MAX_DIMS+1];
   logic [EXT_BITS-1:0] h_ext   [MAX_DIMS];
   logic [EXT_BITS-1:0] h_digit [MAX_DIMS];

   assign h_valid[0]      = d_valid[INDEX_BITS];
   assign h_data[0].oor   = d_data[INDEX_BITS].oor;
   assign h_data[0].acc   = '0;
   assign h_data[0].coord = d_data[INDEX_BITS].coord;

   for (genvar j = 0; j < MAX_DIMS; j++) begin : g_horner
      assign h_ext[j]   = direction_ff ? ext_eff[j] : ext_eff[MAX_DIMS-1-j];
      assign h_digit[j] = direction_ff ? h_data[j].coord[j]
                                       : h_data[j].coord[MAX_DIMS-1-j];
      ndt_horner_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ext_in    (h_ext[j]),
         .digit_in  (h_digit[j]),
         .valid_in  (h_valid[j]),
         .data_in   (h_data[j]),
         .valid_out (h_valid[j+1]),
         .data_out  (h_data[j+1])
      );
   end

   // -------------------------------------------------------- result register
   logic                  rsp_valid_ff;
   logic [INDEX_BITS-1:0] rsp_source_ff;
   logic                  rsp_oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= h_valid[MAX_DIMS];
      end
      // drop the index to zero when out of range
      rsp_source_ff <= h_data[MAX_DIMS].oor ? '0 : h_data[MAX_DIMS].acc;
      rsp_oor_ff    <= h_data[MAX_DIMS].oor;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_source_index = rsp_source_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule
